FILE: rtl/brf_pkg.sv
`default_nettype none

package brf_pkg;

    localparam int SLOTS     = 4096;
    localparam int IDX_W     = $clog2(SLOTS);
    localparam int MOD_W     = IDX_W + 1;
    localparam int MAX_BURST = 64;
    localparam int CNT_W     = 7;
    localparam int BYTE_W    = 8;
    localparam int CMD_W     = 3;

    localparam logic [IDX_W-1:0] CAP_RESET = IDX_W'(SLOTS - 1);

    localparam int S_TDATA_W = 16;
    localparam int S_TUSER_W = CMD_W;
    localparam int M_TDATA_W = 32;
    localparam int M_TUSER_W = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE = 3'd0,
        CMD_READ  = 3'd1,
        CMD_PEEK  = 3'd2,
        CMD_SKIP  = 3'd3,
        CMD_CLEAR = 3'd4
    } cmd_t;

    typedef enum logic {
        ST_IDLE,
        ST_BURST
    } state_t;

    typedef struct packed {
        logic accept;
        logic emit;
    } dp_ctrl_t;

    typedef struct packed {
        logic burst_go;
        logic last_byte;
    } dp_stat_t;

    function automatic logic [IDX_W-1:0] ring_inc(input logic [IDX_W-1:0] idx,
                                                  input logic [MOD_W-1:0] modulus);
        logic [MOD_W-1:0] sum;
        sum = {1'b0, idx} + MOD_W'(1);
        if (sum == modulus)
        begin
            return '0;
        end
        return sum[IDX_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/byte_ring_fifo_burst_top.sv
// channel   | handshake            | payload
// s (cmd)   | s_tvalid / s_tready  | s_tuser cmd; s_tdata wr_byte, count
// m (resp)  | m_tvalid / m_tready  | m_tuser byte_valid, write_accepted; m_tlast; m_tdata
// cfg       | cfg_valid / cfg_ready| cfg_data capacity
//
// Write, skip, clear: one response each.
// Read / peek of n bytes: the accept cycle issues the first RAM read, then one byte per
// cycle from the registered RAM read port while the response is not stalled.
// Reset clears pointers and counts and sets the capacity to 4095; the byte store needs no clearing pass.
// A stalled response holds the output register; no new command is taken meanwhile.
`default_nettype none

module byte_ring_fifo_burst_top
    import brf_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // [7:0] wr_byte, [14:8] count, [15] zero
    input  wire logic [S_TUSER_W-1:0] s_tuser,   // [2:0] cmd
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [M_TDATA_W-1:0] m_tdata,   // [7:0] rd_byte, [19:8] used, [31:20] free
    output logic      [M_TUSER_W-1:0] m_tuser,   // [0] byte_valid, [1] write_accepted
    output logic                      m_tlast,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [IDX_W-1:0]     cfg_data
);

    dp_ctrl_t ctrl;
    dp_stat_t stat;

    assign cfg_ready = 1'b1;

    brf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    brf_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .stat      (stat),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire

FILE: rtl/brf_ram.sv
`default_nettype none

module brf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_array [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_array[waddr] <= wdata;
        end
        rdata_reg <= mem_array[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: rtl/brf_ctrl.sv
`default_nettype none

module brf_ctrl
    import brf_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  wire logic     m_tready,
    input  wire dp_stat_t stat,
    output dp_ctrl_t      ctrl
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        s_tready    = 1'b0;
        ctrl.accept = 1'b0;
        ctrl.emit   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready    = out_free;
                ctrl.accept = s_tvalid && out_free;
                if (ctrl.accept && stat.burst_go)
                begin
                    state_next = ST_BURST;
                end
            end
            ST_BURST:
            begin
                ctrl.emit = out_free;
                if (ctrl.emit && stat.last_byte)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        out_valid_next = (out_valid_reg && !m_tready)
                       || (ctrl.accept && !stat.burst_go)
                       || ctrl.emit;
    end

    assign m_tvalid = out_valid_reg;

endmodule

`default_nettype wire

FILE: rtl/brf_datapath.sv
`default_nettype none

module brf_datapath
    import brf_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire dp_ctrl_t             ctrl,
    output dp_stat_t                  stat,
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    input  wire logic [S_TUSER_W-1:0] s_tuser,
    input  wire logic                 cfg_valid,
    input  wire logic [IDX_W-1:0]     cfg_data,
    output logic      [M_TDATA_W-1:0] m_tdata,
    output logic      [M_TUSER_W-1:0] m_tuser,
    output logic                      m_tlast
);

    cmd_t              in_cmd;
    logic [BYTE_W-1:0] in_byte;
    logic [CNT_W-1:0]  in_cnt;

    logic [IDX_W-1:0] cap_reg,    cap_next;
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic [IDX_W-1:0] wr_idx_reg, wr_idx_next;
    logic [IDX_W-1:0] used_reg,   used_next;
    logic [IDX_W-1:0] cur_reg,    cur_next;
    logic [CNT_W-1:0] rem_reg,    rem_next;
    logic             peek_reg,   peek_next;

    logic [BYTE_W-1:0] out_byte_reg, out_byte_next;
    logic              out_bval_reg, out_bval_next;
    logic              out_last_reg, out_last_next;
    logic              out_acc_reg,  out_acc_next;
    logic [IDX_W-1:0]  out_used_reg, out_used_next;
    logic [IDX_W-1:0]  out_free_reg, out_free_next;
    logic              load_out;

    logic [MOD_W-1:0]  modulus;
    logic              full;
    logic [CNT_W-1:0]  burst_cap;
    logic [CNT_W-1:0]  burst_n;
    logic [IDX_W-1:0]  skip_n;
    logic [MOD_W-1:0]  skip_sum;
    logic [MOD_W-1:0]  skip_wrap;
    logic [IDX_W-1:0]  skip_idx;
    logic [IDX_W-1:0]  cur_inc;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_raddr;
    logic [BYTE_W-1:0] ram_rdata;

    assign in_cmd  = cmd_t'(s_tuser);
    assign in_byte = s_tdata[BYTE_W-1:0];
    assign in_cnt  = s_tdata[BYTE_W+CNT_W-1:BYTE_W];

    assign modulus   = {1'b0, cap_reg} + MOD_W'(1);
    assign full      = (used_reg == cap_reg);
    assign burst_cap = (in_cnt > CNT_W'(MAX_BURST)) ? CNT_W'(MAX_BURST) : in_cnt;
    assign burst_n   = (IDX_W'(burst_cap) > used_reg) ? used_reg[CNT_W-1:0] : burst_cap;
    assign skip_n    = (IDX_W'(in_cnt) > used_reg) ? used_reg : IDX_W'(in_cnt);
    assign skip_sum  = {1'b0, rd_idx_reg} + {1'b0, skip_n};
    assign skip_wrap = skip_sum - modulus;
    assign skip_idx  = (skip_sum >= modulus) ? skip_wrap[IDX_W-1:0] : skip_sum[IDX_W-1:0];
    assign cur_inc   = ring_inc(cur_reg, modulus);

    assign stat.burst_go  = ((in_cmd == CMD_READ) || (in_cmd == CMD_PEEK))
                          && (burst_n != '0);
    assign stat.last_byte = (rem_reg == CNT_W'(1));

    // read port follows the burst cursor; it holds while the output is stalled
    assign ram_we    = ctrl.accept && (in_cmd == CMD_WRITE) && !full;
    assign ram_raddr = ctrl.emit ? cur_inc : (ctrl.accept ? rd_idx_reg : cur_reg);

    brf_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_idx_reg),
        .wdata (in_byte),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        cap_next      = cap_reg;
        rd_idx_next   = rd_idx_reg;
        wr_idx_next   = wr_idx_reg;
        used_next     = used_reg;
        cur_next      = cur_reg;
        rem_next      = rem_reg;
        peek_next     = peek_reg;
        load_out      = 1'b0;
        out_byte_next = '0;
        out_bval_next = 1'b0;
        out_last_next = 1'b1;
        out_acc_next  = 1'b0;
        if (cfg_valid && (cfg_data != '0))
        begin
            cap_next    = cfg_data;
            rd_idx_next = '0;
            wr_idx_next = '0;
            used_next   = '0;
        end
        else if (ctrl.accept)
        begin
            load_out = !stat.burst_go;
            unique case (in_cmd) inside
                CMD_WRITE:
                begin
                    if (!full)
                    begin
                        wr_idx_next  = ring_inc(wr_idx_reg, modulus);
                        used_next    = used_reg + IDX_W'(1);
                        out_acc_next = 1'b1;
                    end
                end
                CMD_READ, CMD_PEEK:
                begin
                    cur_next  = rd_idx_reg;
                    rem_next  = burst_n;
                    peek_next = (in_cmd == CMD_PEEK);
                end
                CMD_SKIP:
                begin
                    rd_idx_next = skip_idx;
                    used_next   = used_reg - skip_n;
                end
                CMD_CLEAR:
                begin
                    rd_idx_next = '0;
                    wr_idx_next = '0;
                    used_next   = '0;
                end
                default:
                begin
                end
            endcase
        end
        else if (ctrl.emit)
        begin
            load_out      = 1'b1;
            cur_next      = cur_inc;
            rem_next      = rem_reg - CNT_W'(1);
            out_byte_next = ram_rdata;
            out_bval_next = 1'b1;
            out_last_next = stat.last_byte;
            if (!peek_reg)
            begin
                rd_idx_next = cur_inc;
                used_next   = used_reg - IDX_W'(1);
            end
        end
        out_used_next = used_next;
        out_free_next = cap_next - used_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg    <= CAP_RESET;
            rd_idx_reg <= '0;
            wr_idx_reg <= '0;
            used_reg   <= '0;
            cur_reg    <= '0;
            rem_reg    <= '0;
            peek_reg   <= 1'b0;
        end
        else
        begin
            cap_reg    <= cap_next;
            rd_idx_reg <= rd_idx_next;
            wr_idx_reg <= wr_idx_next;
            used_reg   <= used_next;
            cur_reg    <= cur_next;
            rem_reg    <= rem_next;
            peek_reg   <= peek_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_byte_reg <= out_byte_next;
            out_bval_reg <= out_bval_next;
            out_last_reg <= out_last_next;
            out_acc_reg  <= out_acc_next;
            out_used_reg <= out_used_next;
            out_free_reg <= out_free_next;
        end
    end

    assign m_tdata = {out_free_reg, out_used_reg, out_byte_reg};
    assign m_tuser = {out_acc_reg, out_bval_reg};
    assign m_tlast = out_last_reg;

endmodule

`default_nettype wire

FILE: rtl/brf_checker.sv
`default_nettype none

module brf_assert
    import brf_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 s_tvalid,
    input wire logic                 s_tready,
    input wire logic [S_TUSER_W-1:0] s_tuser,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata,
    input wire logic [M_TUSER_W-1:0] m_tuser,
    input wire logic                 m_tlast
);

    // stalled response transaction holds
    a_resp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("response changed while stalled");

    a_no_byte_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tlast && (m_tdata[7:0] == 8'd0))
        else $error("byteless response not last or carries data");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("byte_valid and write_accepted both set");

    a_write_responds: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == CMD_WRITE) |=> m_tvalid)
        else $error("write transaction gave no response");

endmodule

bind byte_ring_fifo_burst_top brf_assert u_brf_assert (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire

FILE: tb/brf_checker.sv
`default_nettype none

module brf_checker
    import brf_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    input  wire logic                 s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // [7:0] wr_byte, [14:8] count, [15] zero
    input  wire logic [S_TUSER_W-1:0] s_tuser,   // [2:0] cmd
    input  wire logic                 m_tvalid,
    input  wire logic                 m_tready,
    input  wire logic [M_TDATA_W-1:0] m_tdata,   // [7:0] rd_byte, [19:8] used, [31:20] free
    input  wire logic [M_TUSER_W-1:0] m_tuser,   // [0] byte_valid, [1] write_accepted
    input  wire logic                 m_tlast,
    input  wire logic                 cfg_valid,
    input  wire logic                 cfg_ready,
    input  wire logic [IDX_W-1:0]     cfg_data,
    output int                        errors,
    output int                        pending,
    output int                        checked
);

    typedef struct {
        logic [BYTE_W-1:0] rd_byte;
        logic              byte_valid;
        logic              last;
        logic              wr_ok;
        logic [IDX_W-1:0]  used;
        logic [IDX_W-1:0]  free;
    } fifo_resp_t;

    fifo_resp_t        due_responses[$];
    logic [BYTE_W-1:0] shadow_mem [SLOTS];
    int                rd_ptr;
    int                wr_ptr;
    int                cap_reg;

    function automatic int ring_mod();
        int c;
        c = cap_reg;
        if (c > SLOTS - 1)
            c = SLOTS - 1;
        if (c < 1)
            c = 1;
        return c + 1;
    endfunction

    function automatic int fill_level();
        if (wr_ptr >= rd_ptr)
            return wr_ptr - rd_ptr;
        return ring_mod() - (rd_ptr - wr_ptr);
    endfunction

    function automatic int space_left();
        int cap;
        int held;
        cap  = ring_mod() - 1;
        held = fill_level();
        return (held > cap) ? 0 : cap - held;
    endfunction

    function automatic int ring_bump(input int idx, input int n);
        int i;
        i = idx + n;
        while (i >= ring_mod())
            i -= ring_mod();
        return i;
    endfunction

    function automatic void log_response(input logic [BYTE_W-1:0] b, input logic v,
                                         input logic l, input logic acc);
        fifo_resp_t r;
        r.rd_byte    = b;
        r.byte_valid = v;
        r.last       = l;
        r.wr_ok      = acc;
        r.used       = IDX_W'(fill_level());
        r.free       = IDX_W'(space_left());
        due_responses.push_back(r);
    endfunction

    function automatic void apply_fifo_cmd(input logic [CMD_W-1:0] op,
                                           input logic [BYTE_W-1:0] data,
                                           input logic [CNT_W-1:0] cnt);
        int held;
        int n;
        int idx;
        held = fill_level();
        case (op) inside
            CMD_WRITE:
            begin
                if (space_left() == 0)
                    log_response('0, 1'b0, 1'b1, 1'b0);
                else
                begin
                    shadow_mem[wr_ptr] = data;
                    wr_ptr = ring_bump(wr_ptr, 1);
                    log_response('0, 1'b0, 1'b1, 1'b1);
                end
            end
            CMD_READ, CMD_PEEK:
            begin
                n = (cnt > MAX_BURST) ? MAX_BURST : int'(cnt);
                if (n > held)
                    n = held;
                if (n == 0)
                    log_response('0, 1'b0, 1'b1, 1'b0);
                idx = rd_ptr;
                for (int i = 0; i < n; i++)
                begin
                    logic [BYTE_W-1:0] b;
                    b   = shadow_mem[idx];
                    idx = ring_bump(idx, 1);
                    if (op == CMD_READ)
                        rd_ptr = idx;
                    log_response(b, 1'b1, i == n - 1, 1'b0);
                end
            end
            CMD_SKIP:
            begin
                n = (cnt > held) ? held : int'(cnt);
                rd_ptr = ring_bump(rd_ptr, n);
                log_response('0, 1'b0, 1'b1, 1'b0);
            end
            CMD_CLEAR:
            begin
                rd_ptr = 0;
                wr_ptr = 0;
                log_response('0, 1'b0, 1'b1, 1'b0);
            end
            default:
                log_response('0, 1'b0, 1'b1, 1'b0);
        endcase
    endfunction

    task automatic report_mismatch(input string field, input int want, input int got);
        errors++;
        $display("%0t mismatch on %s: expected %0d, got %0d", $realtime, field, want, got);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            due_responses.delete();
            rd_ptr  = 0;
            wr_ptr  = 0;
            cap_reg = CAP_RESET;
            pending = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (due_responses.size() == 0)
                    report_mismatch("unexpected response transaction", 0, 1);
                else
                begin
                    fifo_resp_t w;
                    w = due_responses.pop_front();
                    checked++;
                    if (m_tdata[7:0] !== w.rd_byte)
                        report_mismatch("rd_byte", w.rd_byte, m_tdata[7:0]);
                    if (m_tuser[0] !== w.byte_valid)
                        report_mismatch("byte_valid", w.byte_valid, m_tuser[0]);
                    if (m_tlast !== w.last)
                        report_mismatch("last", w.last, m_tlast);
                    if (m_tuser[1] !== w.wr_ok)
                        report_mismatch("write_accepted", w.wr_ok, m_tuser[1]);
                    if (m_tdata[19:8] !== w.used)
                        report_mismatch("used_count", w.used, m_tdata[19:8]);
                    if (m_tdata[31:20] !== w.free)
                        report_mismatch("free_count", w.free, m_tdata[31:20]);
                end
            end
            if (cfg_valid && cfg_ready && cfg_data != '0)
            begin
                cap_reg = cfg_data;
                rd_ptr  = 0;
                wr_ptr  = 0;
            end
            if (s_tvalid && s_tready)
                apply_fifo_cmd(s_tuser, s_tdata[7:0], s_tdata[14:8]);
            pending = due_responses.size();
        end
    end

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
`default_nettype none

module tb_top;
    import brf_pkg::*;

    localparam int CYCLE_LIMIT = 800000;
    localparam int PHASE_ITEMS = 65;
    localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;   // [7:0] wr_byte, [14:8] count, [15] zero
    logic [S_TUSER_W-1:0] s_tuser   = '0;   // [2:0] cmd
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;          // [7:0] rd_byte, [19:8] used, [31:20] free
    logic [M_TUSER_W-1:0] m_tuser;          // [0] byte_valid, [1] write_accepted
    logic                 m_tlast;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [IDX_W-1:0]     cfg_data  = '0;

    int errors;
    int pending;
    int checked;
    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    int cap_now       = CAP_RESET;
    int cmds_sent     = 0;
    int cycle_count   = 0;

    always #6 clk = ~clk;

    byte_ring_fifo_burst_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    brf_checker chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending),
        .checked   (checked)
    );

    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // entered and left at a falling edge; valid stays up between back-to-back transactions
    task automatic push_cmd(input logic [CMD_W-1:0] op, input logic [BYTE_W-1:0] data,
                            input logic [CNT_W-1:0] n);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {1'b0, n, data};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
        cmds_sent++;
    endtask

    task automatic hold_until_quiet();
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic drain();
        hold_until_quiet();
        repeat (8) @(negedge clk);
    endtask

    task automatic write_capacity(input int value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= IDX_W'(value);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        if (value != 0)
            cap_now = value;
    endtask

    function automatic logic [CNT_W-1:0] pick_count();
        int r;
        r = $urandom_range(99);
        if (r < 8)
            return '0;
        if (r < 68)
            return CNT_W'($urandom_range(1, 16));
        if (r < 90)
            return CNT_W'($urandom_range(17, MAX_BURST));
        return CNT_W'($urandom_range(MAX_BURST + 1, (1 << CNT_W) - 1));
    endfunction

    initial
    begin
        int caps [6];
        int sent_at_start;
        int r;
        int burst;
        caps = '{1, 0, 9, 4095, 64, 300};
        src_idle_pct  = 30;
        sink_idle_pct = 62;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty FIFO, then byte extremes, clamping and spare commands
        push_cmd(CMD_READ,  8'h00, 7'd5);
        push_cmd(CMD_PEEK,  8'hFF, 7'd0);
        push_cmd(CMD_SKIP,  8'h00, 7'd3);
        push_cmd(CMD_WRITE, 8'h00, 7'd0);
        push_cmd(CMD_WRITE, 8'hFF, 7'h7F);
        push_cmd(CMD_WRITE, 8'hA5, 7'd0);
        push_cmd(CMD_WRITE, 8'h5A, 7'd0);
        push_cmd(CMD_PEEK,  8'h00, 7'd0);
        push_cmd(CMD_PEEK,  8'h00, 7'd2);
        push_cmd(CMD_READ,  8'h00, 7'h7F);
        push_cmd(CMD_WRITE, 8'h3C, 7'd0);
        push_cmd(CMD_WRITE, 8'hC3, 7'd0);
        push_cmd(CMD_WRITE, 8'h81, 7'd0);
        push_cmd(CMD_SKIP,  8'h00, 7'h7F);
        push_cmd(CMD_WRITE, 8'h7E, 7'd0);
        push_cmd(CMD_WRITE, 8'h01, 7'd0);
        push_cmd(CMD_CLEAR, 8'h00, 7'd0);
        push_cmd(CMD_SPARE_LO, 8'h00, 7'd0);
        push_cmd(CMD_SPARE_LO + 1'b1, 8'hFF, 7'h7F);
        push_cmd(CMD_SPARE_HI, 8'h55, 7'd9);
        push_cmd(CMD_WRITE, 8'h42, 7'd0);
        push_cmd(CMD_READ,  8'h00, 7'd64);
        push_cmd(CMD_READ,  8'h00, 7'd1);

        for (int phase = 0; phase < 6; phase++)
        begin
            write_capacity(caps[phase]);
            case (phase / 2)
                0:
                begin
                    src_idle_pct  = 30;
                    sink_idle_pct = 62;
                end
                1:
                begin
                    src_idle_pct  = 62;
                    sink_idle_pct = 30;
                end
                default:
                begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                end
            endcase
            sent_at_start = cmds_sent;
            while (cmds_sent - sent_at_start < PHASE_ITEMS)
            begin
                r = $urandom_range(99);
                if (r < 40)
                begin
                    burst = $urandom_range(1, (cap_now < 67) ? cap_now + 3 : 70);
                    if (burst > PHASE_ITEMS - (cmds_sent - sent_at_start))
                        burst = PHASE_ITEMS - (cmds_sent - sent_at_start);
                    repeat (burst)
                        push_cmd(CMD_WRITE, BYTE_W'($urandom), CNT_W'($urandom));
                end
                else if (r < 60)
                    push_cmd(CMD_READ, BYTE_W'($urandom), pick_count());
                else if (r < 72)
                    push_cmd(CMD_PEEK, BYTE_W'($urandom), pick_count());
                else if (r < 82)
                    push_cmd(CMD_SKIP, BYTE_W'($urandom), pick_count());
                else if (r < 86)
                    push_cmd(CMD_CLEAR, BYTE_W'($urandom), CNT_W'($urandom));
                else if (r < 90)
                    push_cmd(CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI)),
                             BYTE_W'($urandom), CNT_W'($urandom));
                else if (r < 96)
                    push_cmd(CMD_W'($urandom), BYTE_W'($urandom), CNT_W'($urandom));
                else
                    hold_until_quiet();
            end
        end

        drain();
        repeat (20) @(negedge clk);
        $display("Sent %0d commands over reset and six capacities, %0d responses checked.",
                 cmds_sent, checked);
        $display("Covered empty and full rings, clamped bursts, spare opcodes, stall mixes.");
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire

FILE: files.f
rtl/brf_pkg.sv
rtl/brf_ram.sv
rtl/brf_ctrl.sv
rtl/brf_datapath.sv
rtl/byte_ring_fifo_burst_top.sv
rtl/brf_checker.sv
tb/brf_checker.sv
tb/tb_top.sv
